// ===== sv/tetrahedral_lut_interpolation_defines.svh =====
// Assertion macros shared by the tetrahedral LUT interpolation RTL.
// Files that assert include this header; it depends on nothing else.
`ifndef TETRAHEDRAL_LUT_INTERPOLATION_DEFINES_SVH
`define TETRAHEDRAL_LUT_INTERPOLATION_DEFINES_SVH

// Checked on every clock edge, reset included.
`define TLI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// Checked on every clock edge outside reset.
`define TLI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// ===== sv/tlut_pkg.sv =====
// Types, constants and helper functions for the tetrahedral LUT interpolation.
// Used by every module of the block but tlut_ram; depends on nothing.
package tlut_pkg;

  localparam int DIM        = 33;
  localparam int CHANNELS   = 3;
  localparam int COORD_FRAC = 12;
  localparam int VALUE_BITS = 16;

  localparam int CW      = 13;                     // coordinate field width
  localparam int DW      = 16;                     // value field width
  localparam int DEPTH   = DIM * DIM * DIM;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int IDX_W   = $clog2(DIM - 1);
  localparam int TW      = CW + $clog2(DIM);       // scaled coordinate width
  localparam int WW      = TW + 2;                 // signed weight width
  localparam int PW      = WW + DW;                // product width
  localparam int SW      = PW + 2;                 // sum width

  // Input request kinds.
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  typedef struct packed {
    logic                   kind;
    logic [CW-1:0]          red;
    logic [CW-1:0]          green;
    logic [CW-1:0]          blue;
    logic                   last_pixel;
    logic [15:0]            entry_index;
    logic [1:0]             entry_channel;
    logic signed [DW-1:0]   entry_value;
  } pixel_t;

  typedef struct packed {
    logic signed [DW-1:0] out_red;
    logic signed [DW-1:0] out_green;
    logic signed [DW-1:0] out_blue;
    logic                 frame_end;
  } result_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [TW-1:0]    frac;
  } coord_t;

  // Lookup stage output: vertex addresses, weights and the write request.
  typedef struct packed {
    logic                       valid;
    logic                       kind;
    logic                       last_pixel;
    logic [3:0][ADDR_W-1:0]     addr;
    logic [3:0][WW-1:0]         weight;
    logic [15:0]                wr_index;
    logic [1:0]                 wr_channel;
    logic [DW-1:0]              wr_value;
  } lookup_t;

  // Split one coordinate into its cell index and fraction.
  function automatic coord_t split_coord(input logic [CW-1:0] c);
    logic [TW-1:0]    t;
    logic [TW-1:0]    i;
    coord_t           r;
    t = TW'(c) * TW'(DIM - 1);
    i = t >> COORD_FRAC;
    if (i > TW'(DIM - 2)) begin
      i = TW'(DIM - 2);
    end
    r.idx  = i[IDX_W-1:0];
    r.frac = t - (i << COORD_FRAC);
    return r;
  endfunction

endpackage

// ===== sv/tetrahedral_lut_interpolation.sv =====
// Top level of the tetrahedral 3D LUT interpolation pipeline.
// Depends on tlut_pkg, tlut_ram, tlut_addr, tlut_blend and the defines header.
//
// Usage:
//  - Requests arrive on pixel / pixel_valid / pixel_stall. A request with kind
//    write stores one channel of one lattice point and gives no result; a
//    request with kind pixel gives exactly one result on result /
//    result_valid / result_stall, in request order.
//  - A pixel passes the split, lookup, RAM read, product and result stages.
//  - Throughput is one request per cycle unless result_stall holds the pipeline.
//    Each vertex read has its own copy of the LUT per channel (four copies),
//    so the four reads and the write never contend for a port.
//  - A write lands in the RAM in the same stage where pixels read, so a pixel
//    always sees every write accepted before it.
//  - Reset clears all valid bits; the LUT contents are not cleared and must be
//    written before any pixel reads them.
//  - While a result waits under result_stall, the whole pipeline holds and
//    pixel_stall is raised; nothing is lost or repeated.
`include "tetrahedral_lut_interpolation_defines.svh"
module tetrahedral_lut_interpolation import tlut_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    pixel_valid,
  output logic    pixel_stall,
  input  pixel_t  pixel,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  logic    en;
  lookup_t look;

  // The pipeline advances unless a finished result is held.
  assign pixel_stall = result_valid & result_stall;
  assign en          = ~pixel_stall;

  tlut_addr u_addr (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (pixel_valid),
    .in_req   (pixel),
    .look     (look)
  );

  logic                    wr_ok;
  logic [2:0][3:0][DW-1:0] vdata;

  assign wr_ok = en & look.valid & (look.kind == KIND_WRITE)
               & (look.wr_index < 16'(DEPTH));

  // One RAM per vertex and per present channel; absent channels read zero.
  for (genvar c = 0; c < 3; c++) begin : g_chan
    for (genvar v = 0; v < 4; v++) begin : g_vert
      if (c < CHANNELS) begin : g_ram
        tlut_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_ram (
          .clk   (clk),
          .we    (wr_ok & (look.wr_channel == 2'(c))),
          .waddr (look.wr_index[ADDR_W-1:0]),
          .wdata (look.wr_value),
          .re    (en),
          .raddr (look.addr[v]),
          .rdata (vdata[c][v])
        );
      end else begin : g_zero
        assign vdata[c][v] = '0;
      end
    end
  end

  logic               s3_valid, s3_last;
  logic [3:0][WW-1:0] s3_weight;

  // Stage 3: weights wait alongside the RAM read.
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= look.valid & (look.kind == KIND_PIXEL);
    end
    if (en) begin
      s3_last   <= look.last_pixel;
      s3_weight <= look.weight;
    end
  end

  tlut_blend u_blend (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s3_valid),
    .in_last   (s3_last),
    .weight    (s3_weight),
    .vdata     (vdata),
    .res_valid (result_valid),
    .res       (result)
  );

  `TLI_ASSERT_ALWAYS(a_reset_clears, rst |=> !result_valid, "result valid after reset")
  `TLI_ASSERT(a_write_no_result, (en && look.valid && look.kind == KIND_WRITE) |=> !s3_valid,
    "LUT write produced a pixel in flight")
  `TLI_ASSERT(a_pixel_reaches_s3, (en && look.valid && look.kind == KIND_PIXEL) |=> s3_valid,
    "pixel lost after lookup")
  `TLI_ASSERT(a_rise_has_source, $rose(result_valid) |-> $past(u_blend.p_valid),
    "result appeared without a product stage entry")

endmodule

// ===== sv/tlut_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; no package needed.
module tlut_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/tlut_addr.sv =====
// Coordinate split and tetrahedron selection: two pipeline stages.
// Depends on tlut_pkg.
module tlut_addr import tlut_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  input  logic    in_valid,
  input  pixel_t  in_req,
  output lookup_t look
);

  logic   s1_valid;
  pixel_t s1_req;
  coord_t s1_r, s1_g, s1_b;

  // Stage 1: scale each coordinate and split it.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
    if (en) begin
      s1_req <= in_req;
      s1_r   <= split_coord(in_req.red);
      s1_g   <= split_coord(in_req.green);
      s1_b   <= split_coord(in_req.blue);
    end
  end

  logic [TW-1:0]          rf, gf, bf;
  logic signed [WW-1:0]   sr, sg, sb, one;
  logic [ADDR_W-1:0]      id000, ida, idb, id111;
  logic signed [WW-1:0]   w0, wa, wb, w1;

  // Stage 2 logic: base vertex, tetrahedron and its weights.
  always_comb begin
    rf    = s1_r.frac;
    gf    = s1_g.frac;
    bf    = s1_b.frac;
    sr    = $signed({2'b00, rf});
    sg    = $signed({2'b00, gf});
    sb    = $signed({2'b00, bf});
    one   = WW'(1) << COORD_FRAC;
    id000 = ADDR_W'(s1_r.idx) + ADDR_W'(s1_g.idx) * ADDR_W'(DIM)
          + ADDR_W'(s1_b.idx) * ADDR_W'(DIM * DIM);
    id111 = id000 + ADDR_W'(1 + DIM + DIM * DIM);
    if (rf > gf) begin
      if (gf > bf) begin
        ida = id000 + ADDR_W'(1);
        idb = id000 + ADDR_W'(1 + DIM);
        w0 = one - sr; wa = sr - sg; wb = sg - sb; w1 = sb;
      end else if (rf > bf) begin
        ida = id000 + ADDR_W'(1);
        idb = id000 + ADDR_W'(1 + DIM * DIM);
        w0 = one - sr; wa = sr - sb; wb = sb - sg; w1 = sg;
      end else begin
        ida = id000 + ADDR_W'(DIM * DIM);
        idb = id000 + ADDR_W'(1 + DIM * DIM);
        w0 = one - sb; wa = sb - sr; wb = sr - sg; w1 = sg;
      end
    end else begin
      if (bf > gf) begin
        ida = id000 + ADDR_W'(DIM * DIM);
        idb = id000 + ADDR_W'(DIM + DIM * DIM);
        w0 = one - sb; wa = sb - sg; wb = sg - sr; w1 = sr;
      end else if (bf > rf) begin
        ida = id000 + ADDR_W'(DIM);
        idb = id000 + ADDR_W'(DIM + DIM * DIM);
        w0 = one - sg; wa = sg - sb; wb = sb - sr; w1 = sr;
      end else begin
        ida = id000 + ADDR_W'(DIM);
        idb = id000 + ADDR_W'(1 + DIM);
        w0 = one - sg; wa = sg - sr; wb = sr - sb; w1 = sb;
      end
    end
  end

  // Stage 2 register: addresses go straight to the RAM read ports.
  always_ff @(posedge clk) begin
    if (rst) begin
      look.valid <= 1'b0;
    end else if (en) begin
      look.valid <= s1_valid;
    end
    if (en) begin
      look.kind       <= s1_req.kind;
      look.last_pixel <= s1_req.last_pixel;
      look.addr       <= {id111, idb, ida, id000};
      look.weight     <= {w1, wb, wa, w0};
      look.wr_index   <= s1_req.entry_index;
      look.wr_channel <= s1_req.entry_channel;
      look.wr_value   <= s1_req.entry_value;
    end
  end

endmodule

// ===== sv/tlut_blend.sv =====
// Weighted blend of four vertices per channel, rounding and saturation.
// Two stages: products, then sum to the result register. Depends on tlut_pkg.
module tlut_blend import tlut_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic                      in_last,
  input  logic [3:0][WW-1:0]        weight,
  input  logic [2:0][3:0][DW-1:0]   vdata,
  output logic                      res_valid,
  output result_t                   res
);

  localparam logic signed [SW-1:0] VMAX = SW'((64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] VMIN = -VMAX - SW'(1);
  localparam logic signed [SW-1:0] HALF = SW'(1) <<< (COORD_FRAC - 1);

  logic                           p_valid, p_last;
  logic signed [PW-1:0]           prod [3][4];

  // Stage 4: one multiplier per vertex and channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (en) begin
      p_valid <= in_valid;
    end
    if (en) begin
      p_last <= in_last;
      for (int c = 0; c < 3; c++) begin
        for (int v = 0; v < 4; v++) begin
          prod[c][v] <= $signed(weight[v]) * $signed(vdata[c][v]);
        end
      end
    end
  end

  logic signed [SW-1:0] sum  [3];
  logic signed [SW-1:0] rnd  [3];
  logic [DW-1:0]        chan [3];

  // Sum, round to nearest, saturate to the value range.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum[c] = SW'(prod[c][0]) + SW'(prod[c][1]) + SW'(prod[c][2]) + SW'(prod[c][3]);
      rnd[c] = (sum[c] + HALF) >>> COORD_FRAC;
      if (rnd[c] > VMAX) begin
        rnd[c] = VMAX;
      end else if (rnd[c] < VMIN) begin
        rnd[c] = VMIN;
      end
      chan[c] = rnd[c][DW-1:0];
    end
  end

  // Stage 5: result register, held while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= p_valid;
    end
    if (en) begin
      res.out_red   <= chan[0];
      res.out_green <= chan[1];
      res.out_blue  <= chan[2];
      res.frame_end <= p_last;
    end
  end

endmodule

// ===== bench/tlut_checker.sv =====
// Checker for the tetrahedral LUT interpolation: it watches both channels,
// keeps its own copy of the colour cube, predicts every pixel and compares.
// Depends on tlut_pkg.
`timescale 1ns / 1ps
module tlut_checker import tlut_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    pixel_valid,
  input  logic    pixel_stall,
  input  pixel_t  pixel,
  input  logic    result_valid,
  input  logic    result_stall,
  input  result_t result,
  output int      errors,
  output int      pending,
  output int      pixels_checked
);

  // Our own copy of the colour cube, one signed value per channel.
  int cube [DEPTH][3];
  result_t expected_pixels [$];

  // Split a coordinate into cell index and fraction.
  function automatic void cell_of(input logic [CW-1:0] c, output int idx, output int frac);
    int t;
    t = int'(c) * (DIM - 1);
    idx = t >>> COORD_FRAC;
    if (idx > DIM - 2) begin
      idx = DIM - 2;
    end
    frac = t - (idx << COORD_FRAC);
  endfunction

  // Blend four cube vertices per channel for one pixel.
  function automatic result_t interpolate(input pixel_t p);
    int ri, gi, bi, rf, gf, bf, one;
    int base, far_corner, va, vb;
    longint w0, wa, wb, w1, acc, vmax, vmin;
    logic [DW-1:0] chans [3];
    result_t r;
    one = 1 << COORD_FRAC;
    vmax = (longint'(1) << (VALUE_BITS - 1)) - 1;
    vmin = -vmax - 1;
    cell_of(p.red, ri, rf);
    cell_of(p.green, gi, gf);
    cell_of(p.blue, bi, bf);
    base = ri + gi * DIM + bi * DIM * DIM;
    far_corner = base + 1 + DIM + DIM * DIM;
    // Tetrahedron choice; strict comparisons settle ties in this order.
    if (rf > gf) begin
      if (gf > bf) begin
        va = base + 1; vb = base + 1 + DIM;
        w0 = one - rf; wa = rf - gf; wb = gf - bf; w1 = bf;
      end else if (rf > bf) begin
        va = base + 1; vb = base + 1 + DIM * DIM;
        w0 = one - rf; wa = rf - bf; wb = bf - gf; w1 = gf;
      end else begin
        va = base + DIM * DIM; vb = base + 1 + DIM * DIM;
        w0 = one - bf; wa = bf - rf; wb = rf - gf; w1 = gf;
      end
    end else begin
      if (bf > gf) begin
        va = base + DIM * DIM; vb = base + DIM + DIM * DIM;
        w0 = one - bf; wa = bf - gf; wb = gf - rf; w1 = rf;
      end else if (bf > rf) begin
        va = base + DIM; vb = base + DIM + DIM * DIM;
        w0 = one - gf; wa = gf - bf; wb = bf - rf; w1 = rf;
      end else begin
        va = base + DIM; vb = base + 1 + DIM;
        w0 = one - gf; wa = gf - rf; wb = rf - bf; w1 = bf;
      end
    end
    for (int ch = 0; ch < 3; ch++) begin
      acc = 0;
      if (ch < CHANNELS) begin
        acc = w0 * cube[base][ch] + wa * cube[va][ch] + wb * cube[vb][ch]
            + w1 * cube[far_corner][ch];
        // Round half up, then saturate to the value range.
        acc = (acc + (one >>> 1)) >>> COORD_FRAC;
        if (acc > vmax) acc = vmax;
        if (acc < vmin) acc = vmin;
      end
      chans[ch] = acc[DW-1:0];
    end
    r.out_red   = chans[0];
    r.out_green = chans[1];
    r.out_blue  = chans[2];
    r.frame_end = p.last_pixel;
    return r;
  endfunction

  assign pending = expected_pixels.size();

  // Apply accepted requests and check accepted results.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      errors <= 0;
      pixels_checked <= 0;
    end else begin
      if (pixel_valid && !pixel_stall) begin
        if (pixel.kind == KIND_WRITE) begin
          if (pixel.entry_index < DEPTH && pixel.entry_channel < CHANNELS) begin
            cube[pixel.entry_index][pixel.entry_channel] = int'(pixel.entry_value);
          end
        end else begin
          expected_pixels.push_back(interpolate(pixel));
        end
      end
      if (result_valid && !result_stall) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected result %h", $time, result);
          errors <= errors + 1;
        end else begin
          want = expected_pixels.pop_front();
          pixels_checked <= pixels_checked + 1;
          if (want.out_red !== result.out_red || want.out_green !== result.out_green ||
              want.out_blue !== result.out_blue || want.frame_end !== result.frame_end) begin
            $display("%0t: mismatch expected r=%0d g=%0d b=%0d end=%0b",
                     $time, want.out_red, want.out_green, want.out_blue, want.frame_end,
                     " actual r=%0d g=%0d b=%0d end=%0b",
                     result.out_red, result.out_green, result.out_blue, result.frame_end);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

// ===== bench/tb_tetrahedral_lut_interpolation.sv =====
// Testbench top for the tetrahedral LUT interpolation: drives LUT writes and
// pixels with random gaps and stalls, and gives the verdict.
// Depends on tlut_pkg, tlut_checker and the block itself.
`timescale 1ns / 1ps
module tb_tetrahedral_lut_interpolation;
  import tlut_pkg::*;

  logic    clk;
  logic    rst;
  logic    pixel_valid;
  logic    pixel_stall;
  pixel_t  pixel;
  logic    result_valid;
  logic    result_stall;
  result_t result;
  int      errors, pending, pixels_checked;

  int  tx_idle = 6;
  int  rx_idle = 72;
  int  requests_sent = 0;
  int  cycle_count = 0;
  int  hold_left = 0;
  bit  point_written [DEPTH];

  tetrahedral_lut_interpolation dut (
    .clk(clk), .rst(rst), .pixel_valid(pixel_valid), .pixel_stall(pixel_stall),
    .pixel(pixel), .result_valid(result_valid), .result_stall(result_stall),
    .result(result)
  );

  tlut_checker u_checker (
    .clk(clk), .rst(rst), .pixel_valid(pixel_valid), .pixel_stall(pixel_stall),
    .pixel(pixel), .result_valid(result_valid), .result_stall(result_stall),
    .result(result), .errors(errors), .pending(pending),
    .pixels_checked(pixels_checked)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, plus one long hold-off to back the pipe up.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == 2000) begin
        hold_left <= 300;
        result_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        result_stall <= 1'b1;
      end else begin
        result_stall <= ($urandom_range(99) < rx_idle);
      end
    end
  end

  // Offer one request and wait until it is taken.
  task automatic offer_request(input pixel_t p);
    logic stalled;
    while ($urandom_range(99) < tx_idle) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel <= p;
    pixel_valid <= 1'b1;
    forever begin
      @(negedge clk);
      stalled = pixel_stall;
      @(posedge clk);
      if (!stalled) break;
    end
    requests_sent++;
  endtask

  function automatic pixel_t random_fields();
    logic [95:0] bits;
    bits = {$urandom, $urandom, $urandom};
    return bits[$bits(pixel_t)-1:0];
  endfunction

  function automatic logic [DW-1:0] random_value();
    case ($urandom_range(5))
      0: return 16'h7fff;
      1: return 16'h8000;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Store one channel of one lattice point; ignored when out of range.
  task automatic write_entry(input int index, input int channel, input logic [DW-1:0] v);
    pixel_t p;
    p = random_fields();
    p.kind = KIND_WRITE;
    p.entry_index = 16'(index);
    p.entry_channel = 2'(channel);
    p.entry_value = v;
    offer_request(p);
  endtask

  function automatic int cell_index(input int c);
    int i;
    i = (c * (DIM - 1)) >>> COORD_FRAC;
    return (i > DIM - 2) ? DIM - 2 : i;
  endfunction

  // Fill every unwritten corner of the pixel's cell, then send the pixel.
  task automatic interpolate_pixel(input int r, input int g, input int b, input bit last);
    int ri, gi, bi, point;
    pixel_t p;
    ri = cell_index(r);
    gi = cell_index(g);
    bi = cell_index(b);
    for (int k = 0; k < 8; k++) begin
      point = (ri + k[0]) + (gi + k[1]) * DIM + (bi + k[2]) * DIM * DIM;
      if (!point_written[point]) begin
        for (int ch = 0; ch < CHANNELS; ch++) write_entry(point, ch, random_value());
        point_written[point] = 1'b1;
      end
    end
    p = random_fields();
    p.kind = KIND_PIXEL;
    p.red = CW'(r);
    p.green = CW'(g);
    p.blue = CW'(b);
    p.last_pixel = last;
    offer_request(p);
  endtask

  function automatic int random_coord();
    case ($urandom_range(9))
      0: return 0;
      1: return 4096;
      2: return 8191;
      3: return 4095;
      8, 9: return $urandom_range(0, 8191);
      default: return $urandom_range(0, 4096);
    endcase
  endfunction

  initial begin
    int r, g, b, sel;
    rst = 1'b1;
    pixel_valid = 1'b0;
    pixel = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: corners, coordinates past 1.0, all six tetrahedra, ties,
    // full-scale values and writes that must be ignored.
    write_entry(0, 0, 16'h7fff);
    write_entry(0, 3, 16'h1234);
    write_entry(DEPTH, 0, 16'h1111);
    write_entry(65535, 1, 16'hffff);
    interpolate_pixel(0, 0, 0, 1'b0);
    interpolate_pixel(4096, 4096, 4096, 1'b1);
    interpolate_pixel(8191, 8191, 8191, 1'b0);
    interpolate_pixel(30, 20, 10, 1'b0);
    interpolate_pixel(30, 10, 20, 1'b0);
    interpolate_pixel(20, 10, 30, 1'b0);
    interpolate_pixel(10, 20, 30, 1'b0);
    interpolate_pixel(10, 30, 20, 1'b0);
    interpolate_pixel(20, 30, 10, 1'b0);
    interpolate_pixel(2048, 2048, 2048, 1'b0);
    interpolate_pixel(20, 20, 10, 1'b1);
    interpolate_pixel(8191, 0, 4096, 1'b1);

    // Random traffic in three idle/stall regimes.
    for (int phase = 0; phase < 3; phase++) begin
      tx_idle = (phase == 0) ? 6 : (phase == 1) ? 72 : 0;
      rx_idle = (phase == 0) ? 72 : (phase == 1) ? 6 : 0;
      while (requests_sent < 540 * (phase + 1)) begin
        sel = $urandom_range(99);
        if (sel < 5) begin
          write_entry($urandom_range(DEPTH, 65535), $urandom_range(0, 3), random_value());
        end else if (sel < 8) begin
          write_entry($urandom_range(0, DEPTH - 1), 3, random_value());
        end else if (sel < 18) begin
          // Overwrite a point in the lowest cell, which is always written.
          write_entry($urandom_range(0, 1) + $urandom_range(0, 1) * DIM
                      + $urandom_range(0, 1) * DIM * DIM,
                      $urandom_range(0, CHANNELS - 1), random_value());
        end else begin
          r = random_coord();
          g = ($urandom_range(4) == 0) ? r : random_coord();
          b = ($urandom_range(4) == 0) ? g : random_coord();
          interpolate_pixel(r, g, b, 1'($urandom_range(0, 1)));
        end
      end
    end
    pixel_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Covered %0d requests and %0d checked pixels under three gap/stall mixes.",
             requests_sent, pixels_checked);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/tlut_pkg.sv
sv/tlut_ram.sv
sv/tlut_addr.sv
sv/tlut_blend.sv
sv/tetrahedral_lut_interpolation.sv
bench/tlut_checker.sv
bench/tb_tetrahedral_lut_interpolation.sv
